[hw/rtl/wfp_pkg.sv]
package wfp_pkg;

   localparam int LEN_BITS = 64;

   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;

   localparam logic [6:0] LEN_CODE_MAX7 = 7'd125;
   localparam logic [6:0] LEN_CODE_16   = 7'd126;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] MASK_BYTES  = 4'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [3:0] frame_opcode;
      logic [3:0] message_opcode;
      logic       fin_flag;
      logic       frame_end;
   } rsp_item_type;

   typedef struct packed {
      logic out_valid;
      logic full;
   } buf_status_type;

endpackage

[hw/rtl/wfp_parse.sv]
module wfp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   output logic                 res_valid,
   output wfp_pkg::rsp_item_type res_item
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_PAY  = 3'd4
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [15:0]                  header_ff, header_in;
   logic [3:0]                   count_ff, count_in;
   logic [wfp_pkg::LEN_BITS-1:0] len_ff, len_in, len_dec;
   logic [31:0]                  key_ff, key_in;
   logic [1:0]                   idx_ff, idx_in;
   logic [3:0]                   msg_op_ff, msg_op_in;
   logic                         do_after;
   logic                         do_start;
   logic [3:0]                   need;
   logic [7:0]                   key_byte;
   logic [3:0]                   op;

   assign len_dec = len_ff - wfp_pkg::LEN_BITS'(1);

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      msg_op_in = msg_op_ff;
      do_after  = 1'b0;
      do_start  = 1'b0;
      need      = wfp_pkg::EXT64_BYTES;
      key_byte  = 8'h00;
      op        = 4'h0;
      res_valid = 1'b0;
      res_item  = '0;

      case (phase_ff)
         PH_HDR1: begin
            header_in = {header_ff[15:8], in_byte};
            if (in_byte[6:0] > wfp_pkg::LEN_CODE_MAX7) begin
               phase_in = PH_EXT;
               count_in = 4'd0;
               len_in   = '0;
            end else begin
               len_in   = wfp_pkg::LEN_BITS'(in_byte[6:0]);
               do_after = 1'b1;
            end
         end
         PH_EXT: begin
            len_in   = {len_ff[wfp_pkg::LEN_BITS-9:0], in_byte};
            count_in = count_ff + 4'd1;
            need     = (header_ff[6:0] == wfp_pkg::LEN_CODE_16) ?
                       wfp_pkg::EXT16_BYTES : wfp_pkg::EXT64_BYTES;
            do_after = (count_in >= need);
         end
         PH_MASK: begin
            key_in   = {key_ff[23:0], in_byte};
            count_in = count_ff + 4'd1;
            do_start = (count_in >= wfp_pkg::MASK_BYTES);
         end
         PH_PAY: begin
            // key bytes go out most significant first
            if (header_ff[7]) begin
               key_byte = key_ff[{~idx_ff, 3'b000} +: 8];
            end
            idx_in    = idx_ff + 2'd1;
            len_in    = len_dec;
            res_valid = 1'b1;
            res_item.data_byte  = in_byte ^ key_byte;
            res_item.byte_valid = 1'b1;
            res_item.frame_end  = (len_dec == '0);
            if (len_dec == '0) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            header_in = {in_byte, 8'h00};
            phase_in  = PH_HDR1;
         end
      endcase

      if (do_after) begin
         if (header_in[7]) begin
            phase_in = PH_MASK;
            count_in = 4'd0;
            key_in   = '0;
         end else begin
            do_start = 1'b1;
         end
      end

      if (do_start) begin
         op     = header_in[11:8];
         idx_in = 2'd0;
         if (op == wfp_pkg::OP_TEXT || op == wfp_pkg::OP_BINARY) begin
            msg_op_in = op;
         end
         if (len_in == '0) begin
            // empty frame: one marker with no byte
            phase_in           = PH_HDR0;
            res_valid          = 1'b1;
            res_item.frame_end = 1'b1;
         end else begin
            phase_in = PH_PAY;
         end
      end

      res_item.frame_opcode   = header_in[11:8];
      res_item.message_opcode = msg_op_in;
      res_item.fin_flag       = header_in[15];
      res_valid               = res_valid & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         header_ff <= '0;
         count_ff  <= '0;
         len_ff    <= '0;
         key_ff    <= '0;
         idx_ff    <= '0;
         msg_op_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         msg_op_ff <= msg_op_in;
      end
   end

endmodule

[hw/rtl/wfp_out_buf.sv]
module wfp_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wfp_pkg::rsp_item_type   push_item,
   input  logic                    pop,
   output wfp_pkg::rsp_item_type   out_item,
   output wfp_pkg::buf_status_type status
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   wfp_pkg::rsp_item_type out_ff, out_in;
   wfp_pkg::rsp_item_type skid_ff, skid_in;
   logic                  drain;

   assign drain = pop & out_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff) begin
         if (push) begin
            out_in       = push_item;
            out_valid_in = 1'b1;
         end
      end else if (drain) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            if (push) begin
               skid_in = push_item;
            end else begin
               skid_valid_in = 1'b0;
            end
         end else if (push) begin
            out_in = push_item;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         // upstream only pushes here while the skid slot is free
         skid_in       = push_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_item         = out_ff;
   assign status.out_valid = out_valid_ff;
   assign status.full      = skid_valid_ff;

endmodule

[hw/rtl/websocket_frame_parser.sv]
// A byte accepted on req_ is held in the input register, then parsed into the output
// buffer, whose first entry drives rsp_. One byte per cycle while the buffer is not
// full; the per-byte state update is a single step.
// A two-entry output buffer lets input continue while one result waits.
// Reset (synchronous, active high) returns the parser to the first header byte
// and empties the input register and the output buffer.
module websocket_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [11:8] frame_opcode,
                                    // [15:12] message_opcode, [16] fin_flag
   output logic        rsp_tuser,   // byte_valid
   output logic        rsp_tlast    // frame_end
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    req_accept;
   logic                    advance;
   logic                    res_valid;
   wfp_pkg::rsp_item_type   res_item;
   wfp_pkg::rsp_item_type   out_item;
   wfp_pkg::buf_status_type buf_status;

   assign advance     = in_valid_ff & ~buf_status.full;
   assign req_tready  = ~in_valid_ff | advance;
   assign req_accept  = req_tvalid & req_tready;
   assign in_valid_in = req_accept | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   wfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   wfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .pop       (rsp_tready),
      .out_item  (out_item),
      .status    (buf_status)
   );

   assign rsp_tvalid = buf_status.out_valid;
   assign rsp_tdata  = {7'd0, out_item.fin_flag, out_item.message_opcode,
                        out_item.frame_opcode, out_item.data_byte};
   assign rsp_tuser  = out_item.byte_valid;
   assign rsp_tlast  = out_item.frame_end;

   // an empty-frame marker carries no byte and always closes the frame
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata[7:0] == 8'h00))
      else $error("empty-frame result malformed");

   assert property (@(posedge clock) disable iff (reset)
      buf_status.full |-> buf_status.out_valid)
      else $error("skid entry held with empty output register");

   assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
